### hdl/iol_pkg.sv
`timescale 1ns / 1ps

package iol_pkg;

    // List geometry
    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int IDX_W = $clog2(DEPTH);

    // Field widths of the request and response
    localparam int OP_W  = 2;
    localparam int POS_W = 5;
    localparam int CNT_W = 5;
    localparam int ST_W  = 2;
    localparam int VAL_W = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_GET    = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    typedef logic [WIDTH-1:0] word_t;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic             shift_up;
        logic             shift_down;
        logic [POS_W-1:0] pos;
        word_t            value;
    } cell_ctrl_t;

endpackage

### hdl/iol_req_if.sv
`timescale 1ns / 1ps

interface iol_req_if;
    logic                           valid;
    logic                           ready;
    logic [iol_pkg::OP_W-1:0]       opcode;
    logic [iol_pkg::POS_W-1:0]      position;
    logic [iol_pkg::VAL_W-1:0]      value_in;

    modport source (output valid, output opcode, output position, output value_in,
                    input ready);
    modport sink   (input valid, input opcode, input position, input value_in,
                    output ready);
endinterface

### hdl/iol_rsp_if.sv
`timescale 1ns / 1ps

interface iol_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [iol_pkg::VAL_W-1:0]      value_out;
    logic [iol_pkg::ST_W-1:0]       status;
    logic [iol_pkg::CNT_W-1:0]      count;
    logic                           is_empty;

    modport source (output valid, output value_out, output status, output count,
                    output is_empty, input ready);
    modport sink   (input valid, input value_out, input status, input count,
                    input is_empty, output ready);
endinterface

### hdl/iol_cell.sv
`timescale 1ns / 1ps

module iol_cell
(
    input  logic                       clk,
    input  iol_pkg::cell_ctrl_t        ctrl,
    input  logic [iol_pkg::POS_W-1:0]  index,
    input  iol_pkg::word_t             left_word,
    input  iol_pkg::word_t             right_word,
    output iol_pkg::word_t             word
);

    iol_pkg::word_t word_reg;
    iol_pkg::word_t word_next;

    // Pick the next word: take from the left, the new value, the right, or hold
    always_comb
    begin
        word_next = word_reg;
        if (ctrl.shift_up)
        begin
            if (index == ctrl.pos)
                word_next = ctrl.value;
            else if (index > ctrl.pos)
                word_next = left_word;
        end
        else if (ctrl.shift_down)
        begin
            if (index >= ctrl.pos)
                word_next = right_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

### hdl/indexed_ordered_list_top.sv
`timescale 1ns / 1ps
// Channel | Direction | Fields
// req     | in        | opcode[1:0], position[4:0], value_in[31:0]
// rsp     | out       | value_out[31:0], status[1:0], count[4:0], is_empty
//
// One request per cycle while req.ready is high; each response appears in the cycle after its transfer.
// Insert and remove move the whole row of cells at once.
// A registered response stage lets a new request in while rsp is drained.
// req.ready drops only while a response is held and rsp.ready is low.
// rst_n clears the count and the response valid; cell contents need no reset.

module indexed_ordered_list_top
(
    input  logic     clk,
    input  logic     rst_n,
    iol_req_if.sink  req,
    iol_rsp_if.source rsp
);

    logic [iol_pkg::CNT_W-1:0] count_reg;
    logic [iol_pkg::CNT_W-1:0] count_next;
    logic                      rsp_valid_reg;
    logic [iol_pkg::VAL_W-1:0] rsp_value_reg;
    logic [iol_pkg::VAL_W-1:0] rsp_value_next;
    logic [iol_pkg::ST_W-1:0]  rsp_status_reg;
    logic [iol_pkg::ST_W-1:0]  rsp_status_next;

    logic                      accept;
    iol_pkg::cell_ctrl_t       ctrl;
    iol_pkg::word_t            cell_word [iol_pkg::DEPTH];
    iol_pkg::word_t            read_word;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Select the addressed cell for get and remove
    assign read_word = cell_word[req.position[iol_pkg::IDX_W-1:0]];

    // Decode the request against the current count
    always_comb
    begin
        ctrl.shift_up   = 1'b0;
        ctrl.shift_down = 1'b0;
        ctrl.pos        = req.position;
        ctrl.value      = iol_pkg::word_t'(req.value_in);
        count_next      = count_reg;
        rsp_value_next  = '0;
        rsp_status_next = iol_pkg::ST_OK;
        case (req.opcode)
            iol_pkg::OP_INSERT:
            begin
                if (req.position > count_reg)
                    rsp_status_next = iol_pkg::ST_BADPOS;
                else if (count_reg == iol_pkg::CNT_W'(iol_pkg::DEPTH))
                    rsp_status_next = iol_pkg::ST_FULL;
                else
                begin
                    ctrl.shift_up = accept;
                    count_next    = count_reg + iol_pkg::CNT_W'(1);
                end
            end
            iol_pkg::OP_REMOVE,
            iol_pkg::OP_GET:
            begin
                if (count_reg == '0)
                    rsp_status_next = iol_pkg::ST_EMPTY;
                else if (req.position >= count_reg)
                    rsp_status_next = iol_pkg::ST_BADPOS;
                else
                begin
                    rsp_value_next = iol_pkg::VAL_W'(read_word);
                    if (req.opcode == iol_pkg::OP_REMOVE)
                    begin
                        ctrl.shift_down = accept;
                        count_next      = count_reg - iol_pkg::CNT_W'(1);
                    end
                end
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    // Row of storage cells; each sees its neighbors, the first takes the new value and the last takes zero
    genvar gi;
    generate
        for (gi = 0; gi < iol_pkg::DEPTH; gi++)
        begin : g_cell
            iol_pkg::word_t left_w;
            iol_pkg::word_t right_w;
            if (gi == 0)
            begin : g_first
                assign left_w = ctrl.value;
            end
            else
            begin : g_mid_l
                assign left_w = cell_word[gi-1];
            end
            if (gi == iol_pkg::DEPTH - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = cell_word[gi+1];
            end
            iol_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .index      (iol_pkg::POS_W'(gi)),
                .left_word  (left_w),
                .right_word (right_w),
                .word       (cell_word[gi])
            );
        end
    endgenerate

    // Advance count and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Hold the response payload until its transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_value_reg  <= rsp_value_next;
            rsp_status_reg <= rsp_status_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.value_out = rsp_value_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.count     = count_reg;
    assign rsp.is_empty  = (count_reg == '0);

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= iol_pkg::CNT_W'(iol_pkg::DEPTH))
        else $error("count exceeds list depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.opcode == iol_pkg::OP_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ctrl.shift_up) |=>
            (count_reg == $past(count_reg) + iol_pkg::CNT_W'(1)))
        else $error("insert did not grow count");

    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != iol_pkg::ST_OK) |-> (rsp.value_out == '0))
        else $error("data on failed request");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> $stable(count_reg))
        else $error("count moved while response stalled");
`endif

endmodule
